>>> hw/rtl/tkbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkbp_pkg
// Types, phase codes and helper functions for the key structure parser.
// ----------------------------------------------------------------------------
package tkbp_pkg;

  localparam int unsigned CodeW  = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OutW   = 40;

  // field phases, equal to the field codes they emit
  localparam logic [CodeW-1:0] PhVerMajor    = 5'd0;
  localparam logic [CodeW-1:0] PhVerMinor    = 5'd1;
  localparam logic [CodeW-1:0] PhRevMajor    = 5'd2;
  localparam logic [CodeW-1:0] PhRevMinor    = 5'd3;
  localparam logic [CodeW-1:0] PhKeyUsage    = 5'd4;
  localparam logic [CodeW-1:0] PhKeyFlags    = 5'd5;
  localparam logic [CodeW-1:0] PhAuthUsage   = 5'd6;
  localparam logic [CodeW-1:0] PhAlgId       = 5'd7;
  localparam logic [CodeW-1:0] PhEncScheme   = 5'd8;
  localparam logic [CodeW-1:0] PhSigScheme   = 5'd9;
  localparam logic [CodeW-1:0] PhParmSize    = 5'd10;
  localparam logic [CodeW-1:0] PhParmByte    = 5'd11;
  localparam logic [CodeW-1:0] PhPcrSize     = 5'd12;
  localparam logic [CodeW-1:0] PhPcrByte     = 5'd13;
  localparam logic [CodeW-1:0] PhPubKeyLen   = 5'd14;
  localparam logic [CodeW-1:0] PhPubKeyByte  = 5'd15;
  localparam logic [CodeW-1:0] PhEncSize     = 5'd16;
  localparam logic [CodeW-1:0] PhEncByte     = 5'd17;
  localparam logic [CodeW-1:0] PhDone        = 5'd18;

  localparam logic [ValueW-1:0] KeyFlagMaskRst = 32'd7;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             start_of_blob;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  field_code;
    logic [ValueW-1:0] field_value;
    logic              last_field;
  } result_t;

  function automatic logic [2:0] phase_width(input logic [CodeW-1:0] ph);
    logic [2:0] w;
    case (ph)
      PhVerMajor, PhVerMinor, PhRevMajor, PhRevMinor, PhAuthUsage: w = 3'd1;
      PhKeyUsage, PhEncScheme, PhSigScheme:                        w = 3'd2;
      default:                                                     w = 3'd4;
    endcase
    return w;
  endfunction

  function automatic logic is_run_phase(input logic [CodeW-1:0] ph);
    return (ph == PhParmByte) || (ph == PhPcrByte) ||
           (ph == PhPubKeyByte) || (ph == PhEncByte);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tkbp_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkbp_in_stage
// Input register for the byte stream; frees as soon as the parser takes it.
// ----------------------------------------------------------------------------
module tkbp_in_stage
  import tkbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     advance_i,
  output logic          item_valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

>>> hw/rtl/tkbp_field_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkbp_field_fsm
// Field sequencer: tracks phase, byte count, accumulator and run length,
// and forms one result per completed field or run byte.
// ----------------------------------------------------------------------------
module tkbp_field_fsm
  import tkbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ValueW-1:0] cfg_wdata_i,
  input  wire logic              advance_i,
  input  wire in_item_t          item_i,
  output logic                   res_valid_o,
  output result_t                res_o
);

  logic [CodeW-1:0]  phase_q, phase_d;
  logic [1:0]        bif_q, bif_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] mask_q;

  logic [CodeW-1:0]  ph;
  logic [1:0]        bif;
  logic [ValueW-1:0] acc, rem, rem_dec, acc_sh, fval;

  assign ph      = item_i.start_of_blob ? PhVerMajor : phase_q;
  assign bif     = item_i.start_of_blob ? 2'd0 : bif_q;
  assign acc     = item_i.start_of_blob ? '0 : acc_q;
  assign rem     = item_i.start_of_blob ? '0 : rem_q;
  assign rem_dec = rem - 32'd1;
  assign acc_sh  = {acc[ValueW-ByteW-1:0], item_i.data_byte};
  assign fval    = (ph == PhKeyFlags) ? (acc_sh & mask_q) : acc_sh;

  always_comb begin
    phase_d     = phase_q;
    bif_d       = bif_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (advance_i) begin
      phase_d = ph;
      bif_d   = bif;
      acc_d   = acc;
      rem_d   = rem;
      if (ph < PhDone) begin
        if (is_run_phase(ph)) begin
          res_valid_o       = 1'b1;
          res_o.field_code  = ph;
          res_o.field_value = {{(ValueW-ByteW){1'b0}}, item_i.data_byte};
          rem_d             = rem_dec;
          if (rem_dec == '0) begin
            if (ph == PhEncByte) begin
              res_o.last_field = 1'b1;
              phase_d          = PhDone;
            end else begin
              phase_d = ph + 5'd1;
            end
          end
        end else if (({1'b0, bif} + 3'd1) < phase_width(ph)) begin
          bif_d = bif + 2'd1;
          acc_d = acc_sh;
        end else begin
          res_valid_o       = 1'b1;
          res_o.field_code  = ph;
          res_o.field_value = fval;
          bif_d             = 2'd0;
          acc_d             = '0;
          if (ph >= PhParmSize) begin
            rem_d = fval;
            if (fval != '0) begin
              phase_d = ph + 5'd1;
            end else if (ph == PhEncSize) begin
              res_o.last_field = 1'b1;
              phase_d          = PhDone;
            end else begin
              phase_d = ph + 5'd2;
            end
          end else begin
            phase_d = ph + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhVerMajor;
      bif_q   <= 2'd0;
      acc_q   <= '0;
      rem_q   <= '0;
      mask_q  <= KeyFlagMaskRst;
    end else begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tkbp_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkbp_out_stage
// Result register; holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tkbp_out_stage
  import tkbp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         can_load_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

>>> hw/rtl/tpm_key_blob_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpm_key_blob_parser
// Byte-serial parser for a TPM 1.1 key structure.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and emits each decoded field with its field code:
// version bytes, key usage, masked key flags, auth usage, algorithm
// parameters, then the parameter, PCR info, public key and encrypted data
// runs byte by byte. tlast marks the final result of a structure; bytes after
// it give no result until tuser marks the start of a new structure. A byte
// passes an input register and the field sequencer into a result register;
// the block sustains one byte per cycle, and the only stall is a held
// result with tready low.
module tpm_key_blob_parser
  import tkbp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ValueW-1:0] cfg_wdata_i,   // key_flag_mask
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [ByteW-1:0]  s_axis_tdata_i, // [7:0] data_byte
  input  wire logic              s_axis_tuser_i, // [0] start_of_blob
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [OutW-1:0]        m_axis_tdata_o, // [4:0] field_code, [36:5] field_value
  output logic                   m_axis_tlast_o  // last_field
);

  in_item_t in_item, item;
  result_t  res, res_out;
  logic     item_valid, can_load, advance, res_valid;

  assign in_item.data_byte     = s_axis_tdata_i;
  assign in_item.start_of_blob = s_axis_tuser_i;
  assign advance               = item_valid && can_load;

  tkbp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tkbp_field_fsm u_field_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tkbp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res_out)
  );

  assign m_axis_tdata_o = {{(OutW-CodeW-ValueW){1'b0}}, res_out.field_value,
                           res_out.field_code};
  assign m_axis_tlast_o = res_out.last_field;

endmodule
`default_nettype wire

>>> tb/tpm_key_blob_parser_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpm_key_blob_parser_test
// Self-checking testbench for the byte-serial key structure parser.
// ----------------------------------------------------------------------------
// Bytes go in over the slave stream. A behavioral decoder keeps its own copy
// of the field sequencer and the flag mask, and it queues the expected
// (code, value, last) result for each completed field or run byte. Every
// result taken from the master stream is compared against the oldest queued
// entry. The directed tests cover a structure sent without a start mark,
// all-ones and all-zero fields, trailing bytes that are ignored, and a pause
// inside a multi-byte field. The random tests then mix well-formed
// structures, truncated ones, huge length prefixes and noise. They run under
// several flag masks and several sender and receiver idle rates.
// ----------------------------------------------------------------------------
module tpm_key_blob_parser_test;
  import tkbp_pkg::*;

  localparam int unsigned HeaderBytes = 19;
  localparam int unsigned RunCap      = 8;
  localparam int unsigned SettleCyc   = 8;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [ValueW-1:0] cfg_wdata = '0;
  logic              s_valid   = 1'b0;
  logic              s_ready;
  logic [ByteW-1:0]  s_data    = '0;
  logic              s_user    = 1'b0;
  logic              m_valid;
  logic              m_ready   = 1'b0;
  logic [OutW-1:0]   m_data;
  logic              m_last;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned err_cnt       = 0;

  logic [ValueW-1:0] flag_mask = KeyFlagMaskRst;
  logic [CodeW-1:0]  fld_phase = PhVerMajor;
  int                fld_byte  = 0;
  logic [ValueW-1:0] fld_acc   = '0;
  logic [ValueW-1:0] run_left  = '0;

  result_t          pending_fields [$];
  logic [ByteW-1:0] blob_bytes [$];

  tpm_key_blob_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected result: code %0d value %h last %0b", $time,
                 m_data[4:0], m_data[36:5], m_last);
        err_cnt++;
      end else begin
        exp_r = pending_fields.pop_front();
        if (m_data[4:0] !== exp_r.field_code || m_data[36:5] !== exp_r.field_value ||
            m_last !== exp_r.last_field) begin
          $display({"%0t: mismatch: expected code %0d value %h last %0b, ",
                    "got code %0d value %h last %0b"},
                   $time, exp_r.field_code, exp_r.field_value, exp_r.last_field,
                   m_data[4:0], m_data[36:5], m_last);
          err_cnt++;
        end
      end
    end
  end

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic sob);
    result_t r;
    int      width;
    if (sob) begin
      fld_phase = PhVerMajor;
      fld_byte  = 0;
      fld_acc   = '0;
      run_left  = '0;
    end
    if (fld_phase >= PhDone) return;
    r.field_code = fld_phase;
    r.last_field = 1'b0;
    if (fld_phase inside {PhParmByte, PhPcrByte, PhPubKeyByte, PhEncByte}) begin
      r.field_value = {{(ValueW-ByteW){1'b0}}, b};
      run_left = run_left - 1;
      if (run_left == 0) begin
        if (fld_phase == PhEncByte) begin
          r.last_field = 1'b1;
          fld_phase    = PhDone;
        end else begin
          fld_phase = fld_phase + 5'd1;
        end
      end
    end else begin
      fld_acc = {fld_acc[ValueW-ByteW-1:0], b};
      case (fld_phase)
        PhVerMajor, PhVerMinor, PhRevMajor, PhRevMinor, PhAuthUsage: width = 1;
        PhKeyUsage, PhEncScheme, PhSigScheme: width = 2;
        default: width = 4;
      endcase
      if (fld_byte + 1 < width) begin
        fld_byte++;
        return;
      end
      r.field_value = fld_acc;
      if (fld_phase == PhKeyFlags) r.field_value = r.field_value & flag_mask;
      fld_byte = 0;
      fld_acc  = '0;
      if (fld_phase >= PhParmSize) begin
        run_left = r.field_value;
        if (run_left != 0) begin
          fld_phase = fld_phase + 5'd1;
        end else if (fld_phase == PhEncSize) begin
          r.last_field = 1'b1;
          fld_phase    = PhDone;
        end else begin
          fld_phase = fld_phase + 5'd2;
        end
      end else begin
        fld_phase = fld_phase + 5'd1;
      end
    end
    pending_fields.push_back(r);
  endtask

  function automatic logic [ByteW-1:0] rand_byte();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return ByteW'($urandom_range(255));
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] b, input logic sob);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_valid = 1'b0;
    end
    @(negedge clk_i);
    s_valid = 1'b1;
    s_data  = b;
    s_user  = sob;
    do @(posedge clk_i); while (!s_ready);
    decode_byte(b, sob);
  endtask

  task automatic wait_fields_done();
    @(negedge clk_i);
    s_valid = 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_flag_mask(input logic [ValueW-1:0] v);
    wait_fields_done();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    flag_mask = v;
  endtask

  task automatic build_blob(input logic [ValueW-1:0] run_len [4]);
    logic [ValueW-1:0] n;
    blob_bytes.delete();
    repeat (HeaderBytes) blob_bytes.push_back(rand_byte());
    for (int k = 0; k < 4; k++) begin
      for (int s = 3; s >= 0; s--) blob_bytes.push_back(run_len[k][8*s +: 8]);
      n = (run_len[k] > RunCap) ? RunCap : run_len[k];
      repeat (n) blob_bytes.push_back(rand_byte());
    end
  endtask

  task automatic send_blob(input int cut, input int pause_at, input logic mark_start);
    for (int i = 0; i < cut; i++) begin
      if (i == pause_at) wait_fields_done();
      push_byte(blob_bytes[i], mark_start && (i == 0));
    end
  endtask

  task automatic test_no_start_mark();
    logic [ValueW-1:0] lens [4];
    lens = '{default: '0};
    build_blob(lens);
    for (int i = 0; i < HeaderBytes; i++) blob_bytes[i] = 8'hFF;
    send_blob(blob_bytes.size(), -1, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
  endtask

  task automatic test_runs_with_pause();
    logic [ValueW-1:0] lens [4];
    set_flag_mask(32'hFFFF_FFFF);
    lens = '{default: 32'd1};
    build_blob(lens);
    for (int i = 0; i < HeaderBytes; i++) blob_bytes[i] = 8'h00;
    blob_bytes[8] = 8'hA5;
    send_blob(blob_bytes.size(), 8, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input logic [ValueW-1:0] mask, input int n_items);
    logic [ValueW-1:0] lens [4];
    int                sent;
    int                kind;
    int                cut;
    int                pause_at;
    int                n;
    set_flag_mask(mask);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind >= 95) begin
        n = $urandom_range(20, 4);
        repeat (n) push_byte(rand_byte(), $urandom_range(3) == 0);
        sent += n;
      end else begin
        for (int k = 0; k < 4; k++)
          lens[k] = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(5);
        if (kind >= 90)
          lens[$urandom_range(3)] = $urandom_range(1) ? 32'hFFFF_FFFF
                                                       : ($urandom | 32'h0001_0000);
        build_blob(lens);
        cut = (kind >= 75 && kind < 90) ? $urandom_range(blob_bytes.size() - 1, 1)
                                        : blob_bytes.size();
        pause_at = ($urandom_range(9) == 0) ? $urandom_range(cut - 1) : -1;
        send_blob(cut, pause_at, 1'b1);
        sent += cut;
        if (kind < 75) repeat ($urandom_range(2)) push_byte(rand_byte(), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_no_start_mark();
    test_runs_with_pause();
    test_random_traffic(0, 0, 32'h0000_0000, 425);
    test_random_traffic(47, 0, $urandom, 425);
    test_random_traffic(0, 47, 32'hFFFF_FFFF, 425);
    test_random_traffic(20, 20, KeyFlagMaskRst, 425);
    wait_fields_done();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/tkbp_pkg.sv
hw/rtl/tkbp_in_stage.sv
hw/rtl/tkbp_field_fsm.sv
hw/rtl/tkbp_out_stage.sv
hw/rtl/tpm_key_blob_parser.sv
tb/tpm_key_blob_parser_test.sv
